// ----- src/gcr62_pkg.sv -----
// Shared types and constants for the 6-and-2 GCR sector decoder.
// Holds the inverse write table, the sector layout and the stage structs.
// No dependencies.
package gcr62_pkg;

  // Sector layout, counted in disk bytes
  localparam int unsigned AuxLen    = 86;
  localparam int unsigned BodyLen   = 342;
  localparam int unsigned SectorLen = 343;

  localparam int unsigned POS_W  = 9;   // holds 0..SectorLen
  localparam int unsigned AUX_AW = 7;   // addresses 0..AuxLen-1
  localparam int unsigned VAL_W  = 6;

  localparam logic [POS_W-1:0]  AUX_END    = POS_W'(AuxLen);
  localparam logic [POS_W-1:0]  BODY_END   = POS_W'(BodyLen);
  localparam logic [POS_W-1:0]  SECTOR_END = POS_W'(SectorLen);
  localparam logic [AUX_AW-1:0] AUX_LAST   = AUX_AW'(AuxLen - 1);

  // Marks a disk code with no 6-bit value
  localparam logic [7:0] INV_BAD = 8'hFF;

  // Inverse write table, indexed by the disk byte with bit 7 stripped
  localparam logic [7:0] INV_TABLE [128] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0,  8'd1,
    8'hFF, 8'hFF, 8'd2,  8'd3,  8'hFF, 8'd4,  8'd5,  8'd6,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd7,  8'd8,
    8'hFF, 8'hFF, 8'hFF, 8'd9,  8'd10, 8'd11, 8'd12, 8'd13,
    8'hFF, 8'hFF, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19,
    8'hFF, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'd27, 8'hFF, 8'd28, 8'd29, 8'd30,
    8'hFF, 8'hFF, 8'hFF, 8'd31, 8'hFF, 8'hFF, 8'd32, 8'd33,
    8'hFF, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd41, 8'd42, 8'd43,
    8'hFF, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50,
    8'hFF, 8'hFF, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
    8'hFF, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63
  };

  // Aux store access issued by the front stage
  typedef struct packed {
    logic              we;
    logic [AUX_AW-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [AUX_AW-1:0] raddr;
  } mem_req_t;

  // Main byte waiting for its aux entry
  typedef struct packed {
    logic [VAL_W-1:0] hi6;
    logic [7:0]       idx;
    logic [1:0]       part;
    logic             err;
  } item_t;

endpackage

// ----- src/gcr62_sector_decoder.sv -----
// 6-and-2 GCR sector body decoder. Feed the 343 disk bytes of a sector body,
// the first one flagged by tuser; it returns 256 data bytes, the last with
// tlast and all with the error status so far. The block takes one disk byte
// per cycle while the output side does not stall it; a main byte waits in
// the hold register while its aux entry is read through the registered read
// port of the aux store memory, then moves into the output register. The aux
// store has no reset and needs no clearing pass.
// Depends on gcr62_pkg, gcr62_front and gcr62_aux_mem.
module gcr62_sector_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] disk_byte
  input  logic        s_axis_tuser_i,   // [0] sector_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] byte_index
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] status
);

  gcr62_pkg::mem_req_t         mem_req;
  logic [gcr62_pkg::VAL_W-1:0] aux_rdata;
  logic                        item_valid;
  gcr62_pkg::item_t            item;
  logic                        advance;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  data_q, data_d, idx_q;
  logic                        last_q, status_q;
  logic [1:0]                  pair;

  gcr62_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .disk_byte_i    (s_axis_tdata_i),
    .sector_start_i (s_axis_tuser_i),
    .advance_i      (advance),
    .mem_req_o      (mem_req),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  gcr62_aux_mem u_aux_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (aux_rdata)
  );

  // Move the held byte on when the output register is free
  assign advance = item_valid && (!out_valid_q || m_axis_tready_i);

  // Pick the aux pair for this third and swap its bits
  always_comb begin
    case (item.part)
      2'd0:    pair = aux_rdata[1:0];
      2'd1:    pair = aux_rdata[3:2];
      default: pair = aux_rdata[5:4];
    endcase
    data_d = item.err ? 8'h00 : {item.hi6, pair[0], pair[1]};
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load payload on each transfer into the output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q   <= data_d;
      idx_q    <= item.idx;
      last_q   <= (item.idx == 8'hFF);
      status_q <= item.err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {idx_q, data_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = status_q;

`ifndef SYNTHESIS
  // Input stalls only while a byte is held for the output side
  a_ready_only_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (item_valid && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a held byte");

  // Last byte of a sector is index 255
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[15:8] == 8'hFF))
    else $error("tlast on a byte other than index 255");

  // Error status forces zero data
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[7:0] == 8'h00))
    else $error("nonzero data after a bad disk byte");
`endif

endmodule

// ----- src/gcr62_aux_mem.sv -----
// Auxiliary store: 86 x 6-bit memory, one write and one registered read port.
// Depends on gcr62_pkg for widths and the request struct.
module gcr62_aux_mem (
  input  logic                             clk_i,
  input  gcr62_pkg::mem_req_t              req_i,
  output logic [gcr62_pkg::VAL_W-1:0]      rdata_o
);

  logic [gcr62_pkg::VAL_W-1:0] mem_q [gcr62_pkg::AuxLen];
  logic [gcr62_pkg::VAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gcr62_front.sv -----
// Front stage: translation, running xor, sector position and aux addressing.
// Holds one main byte while its aux read is in flight. Depends on gcr62_pkg.
module gcr62_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            disk_byte_i,
  input  logic                  sector_start_i,
  input  logic                  advance_i,
  output gcr62_pkg::mem_req_t   mem_req_o,
  output logic                  item_valid_o,
  output gcr62_pkg::item_t      item_o
);

  logic [gcr62_pkg::POS_W-1:0]  pos_q, pos_d, eff_pos;
  logic [gcr62_pkg::VAL_W-1:0]  xor_q, xor_d, eff_xor, xor_new;
  logic                         err_q, err_d, eff_err, err_new;
  logic [gcr62_pkg::AUX_AW-1:0] mod_q, mod_d, eff_mod;
  logic [1:0]                   part_q, part_d, eff_part;
  logic                         item_valid_q, item_valid_d;
  gcr62_pkg::item_t             item_q, item_d;
  logic                         fire, in_body, is_aux, is_main;
  logic [7:0]                   lookup;
  logic                         bad;

  assign in_ready_o = !item_valid_q || advance_i;
  assign fire       = in_valid_i && in_ready_o;

  // Sector start clears state before the byte is used
  always_comb begin
    eff_pos  = sector_start_i ? '0 : pos_q;
    eff_xor  = sector_start_i ? '0 : xor_q;
    eff_err  = sector_start_i ? 1'b0 : err_q;
    eff_mod  = sector_start_i ? '0 : mod_q;
    eff_part = sector_start_i ? '0 : part_q;
  end

  // Translate and fold into the running xor
  always_comb begin
    lookup  = gcr62_pkg::INV_TABLE[disk_byte_i[6:0]];
    bad     = (lookup == gcr62_pkg::INV_BAD);
    err_new = eff_err || bad;
    xor_new = bad ? eff_xor : (eff_xor ^ lookup[gcr62_pkg::VAL_W-1:0]);
    in_body = (eff_pos < gcr62_pkg::BODY_END);
    is_aux  = (eff_pos < gcr62_pkg::AUX_END);
    is_main = in_body && !is_aux;
  end

  // Next state of the sector bookkeeping
  always_comb begin
    pos_d  = pos_q;
    xor_d  = xor_q;
    err_d  = err_q;
    mod_d  = mod_q;
    part_d = part_q;
    if (fire) begin
      pos_d  = eff_pos;
      xor_d  = eff_xor;
      err_d  = eff_err;
      mod_d  = eff_mod;
      part_d = eff_part;
      if (eff_pos < gcr62_pkg::SECTOR_END) begin
        pos_d = eff_pos + 1'b1;
      end
      if (in_body) begin
        xor_d = xor_new;
        err_d = err_new;
      end
      if (is_main) begin
        if (eff_mod == gcr62_pkg::AUX_LAST) begin
          mod_d  = '0;
          part_d = eff_part + 1'b1;
        end else begin
          mod_d = eff_mod + 1'b1;
        end
      end
    end
  end

  // Aux store write for aux bytes, read for main bytes
  always_comb begin
    mem_req_o.we    = fire && is_aux;
    mem_req_o.waddr = eff_pos[gcr62_pkg::AUX_AW-1:0];
    mem_req_o.wdata = xor_new;
    mem_req_o.re    = fire && is_main;
    mem_req_o.raddr = eff_mod;
  end

  // Hold stage: main byte waits here for its aux data
  always_comb begin
    item_d      = item_q;
    item_valid_d = item_valid_q;
    if (advance_i) begin
      item_valid_d = 1'b0;
    end
    if (fire && is_main) begin
      item_valid_d = 1'b1;
      item_d.hi6   = xor_new;
      item_d.idx   = 8'(eff_pos - gcr62_pkg::AUX_END);
      item_d.part  = eff_part;
      item_d.err   = err_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      xor_q        <= '0;
      err_q        <= 1'b0;
      mod_q        <= '0;
      part_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      xor_q        <= xor_d;
      err_q        <= err_d;
      mod_q        <= mod_d;
      part_q       <= part_d;
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for gcr62_sector_decoder: sector bodies in, data bytes out,
// each result checked against an in-bench 6-and-2 decode. Depends on gcr62_pkg.
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned STALL_CYCLES = 300;

  // Forward write table: 6-bit value k is written to disk as WRITE_CODE[k]
  localparam logic [7:0] WRITE_CODE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
    logic       status;
  } sector_byte_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // [7:0] disk_byte
  logic        s_axis_tuser_i = 1'b0;    // [0] sector_start
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;           // [7:0] data_byte, [15:8] byte_index
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;           // [0] status

  // Decoder state as the bench tracks it
  logic [5:0]   aux_copy [86];
  logic [5:0]   xor_acc = '0;
  int unsigned  body_pos = 0;
  logic         bad_seen = 1'b0;
  sector_byte_t pending_bytes [$];

  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 72;
  logic        rx_hold = 1'b0;
  int unsigned disk_bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  gcr62_sector_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Returns {invalid, value} for a disk byte, bit 7 ignored
  function automatic logic [6:0] gcr_lookup(input logic [7:0] disk_byte);
    for (int k = 0; k < 64; k++)
      if (WRITE_CODE[k][6:0] == disk_byte[6:0]) return {1'b0, 6'(k)};
    return {1'b1, 6'd0};
  endfunction

  // Advance the tracked state by one accepted disk byte; queue any data byte
  function automatic void decode_disk_byte(input logic [7:0] disk_byte, input logic start);
    logic [6:0]   look;
    int unsigned  slot;
    int unsigned  third;
    logic [1:0]   pair;
    sector_byte_t exp_byte;
    look = gcr_lookup(disk_byte);
    if (start) begin
      body_pos = 0;
      bad_seen = 1'b0;
      xor_acc  = '0;
    end
    if (body_pos >= gcr62_pkg::SectorLen) return;
    slot = body_pos;
    body_pos++;
    // checksum byte is swallowed
    if (slot >= gcr62_pkg::BodyLen) return;
    if (look[6]) bad_seen = 1'b1;
    else xor_acc = xor_acc ^ look[5:0];
    if (slot < gcr62_pkg::AuxLen) begin
      aux_copy[slot] = xor_acc;
      return;
    end
    slot  = slot - gcr62_pkg::AuxLen;
    third = slot / gcr62_pkg::AuxLen;
    pair  = 2'(aux_copy[slot % gcr62_pkg::AuxLen] >> (2 * third));
    exp_byte.data   = bad_seen ? 8'h00 : {xor_acc, pair[0], pair[1]};
    exp_byte.index  = 8'(slot);
    exp_byte.last   = (slot == 255);
    exp_byte.status = bad_seen;
    pending_bytes.push_back(exp_byte);
  endfunction

  function automatic logic [7:0] random_bad_code();
    logic [7:0] code;
    logic [6:0] look;
    do begin
      code = 8'($urandom_range(255));
      look = gcr_lookup(code);
    end while (!look[6]);
    return code;
  endfunction

  function automatic logic [7:0] random_good_code();
    logic [7:0] code;
    code = WRITE_CODE[$urandom_range(63)];
    // bit 7 must not matter
    if ($urandom_range(7) == 0) code[7] = 1'b0;
    return code;
  endfunction

  // Offer one disk byte; called and returns at a falling edge
  task automatic send_disk_byte(input logic [7:0] disk_byte, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= disk_byte;
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_disk_byte(disk_byte, start);
    disk_bytes_sent++;
    @(negedge clk_i);
  endtask

  // One sector body of body_len bytes, a bad code at bad_at, then stray bytes
  task automatic send_sector(input int body_len, input int bad_at, input int trailing);
    logic [7:0] code;
    for (int p = 0; p < body_len; p++) begin
      code = (p == bad_at) ? random_bad_code() : random_good_code();
      send_disk_byte(code, p == 0);
    end
    for (int t = 0; t < trailing; t++)
      send_disk_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // Hold tready low when asked, otherwise drop it at random
  always @(negedge clk_i)
    m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Compare each output transfer with the oldest expected data byte
  always @(posedge clk_i) begin
    sector_byte_t exp_byte;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected data byte 0x%0h at index %0d",
               m_axis_tdata_o[7:0], m_axis_tdata_o[15:8]);
        mismatches++;
      end else begin
        exp_byte = pending_bytes.pop_front();
        check_field("data_byte", 32'(exp_byte.data), 32'(m_axis_tdata_o[7:0]));
        check_field("byte_index", 32'(exp_byte.index), 32'(m_axis_tdata_o[15:8]));
        check_field("last", 32'(exp_byte.last), 32'(m_axis_tlast_o));
        check_field("status", 32'(exp_byte.status), 32'(m_axis_tuser_o));
      end
    end
  end

  // Field extremes, bad codes and a restart, all inside the aux area
  task automatic test_corner_bytes();
    logic [7:0] corner [16] = '{
      8'h96, 8'hFF, 8'h7F, 8'h80, 8'h00, 8'h16, 8'hD5, 8'hAA,
      8'hEB, 8'h6B, 8'h01, 8'hFE, 8'h9F, 8'h40, 8'hC0, 8'h3F
    };
    for (int k = 0; k < 16; k++) send_disk_byte(corner[k], k == 0 || k == 12);
    // sector that opens on a bad code
    send_disk_byte(8'h00, 1'b1);
    send_disk_byte(8'hFF, 1'b0);
  endtask

  // Full clean sector, then bytes past its end that must be ignored
  task automatic test_clean_sector();
    send_sector(gcr62_pkg::SectorLen, -1, 4);
  endtask

  // Bad code in the aux area zeroes the whole sector
  task automatic test_error_sector();
    send_sector(gcr62_pkg::SectorLen, 40, 0);
  endtask

  // Receiver holds off while the sender keeps offering a sector
  task automatic test_output_stall();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(negedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    send_sector(gcr62_pkg::SectorLen, -1, 0);
  endtask

  // Mostly well-formed sectors with random content, plus errors and noise
  task automatic run_random_sectors(input int unsigned n_items);
    int unsigned first;
    int unsigned pick;
    int unsigned n_noise;
    first = disk_bytes_sent;
    while (disk_bytes_sent - first < n_items) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3: begin
          send_sector(gcr62_pkg::SectorLen, -1, $urandom_range(3));
        end
        4, 5: begin
          send_sector(gcr62_pkg::SectorLen, $urandom_range(gcr62_pkg::BodyLen), 0);
        end
        6: begin
          // checksum position takes a bad code without error
          send_sector(gcr62_pkg::SectorLen, gcr62_pkg::BodyLen, $urandom_range(2));
        end
        7: begin
          send_sector($urandom_range(gcr62_pkg::BodyLen, 1), -1, 0);
        end
        default: begin
          n_noise = $urandom_range(40, 5);
          for (int k = 0; k < n_noise; k++)
            send_disk_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_corner_bytes();
    test_clean_sector();
    test_error_sector();
    run_random_sectors(270);

    send_idle_pct = 72;
    recv_idle_pct = 32;
    run_random_sectors(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    run_random_sectors(270);

    s_axis_tvalid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
